FILE: sv/fcba_pkg.sv
package fcba_pkg;

    localparam int WORD_BITS = 32;
    localparam int WORD_SH   = 5;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_NEXT  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [9:0] block_index;
        logic       link_previous;
    } req_t;

    typedef struct packed {
        logic [9:0] result_block;
        logic [1:0] status;
    } rsp_t;

endpackage

FILE: sv/fat_chain_block_allocator.sv
// File allocation table chain allocator.
// Requests arrive on in_valid/in_ready/in_data (command, block_index,
// link_previous); one response per request leaves on
// out_valid/out_ready/out_data (result_block, status).
// One request is worked on at a time; in_ready is high only while idle.
// Work done per request:
//   allocate: a scan of the used-mark memory, one 32-bit word per cycle;
//   free:     a read then a write of the link memory for each chain entry
//             visited;
//   next:     one read of the link memory; out-of-range or unused command:
//             straight to the response.
// The response sits in an output register; a new request may be accepted
// while it waits. If the receiver stalls, the next finished response is
// held until the output register empties.
// After reset the block clears both memories, one entry per cycle, with
// in_ready low.
// result_block carries the low 10 bits of the block number.
module fat_chain_block_allocator #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fcba_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output fcba_pkg::rsp_t out_data
);

    localparam int BW        = $clog2(NUM_BLOCKS);
    localparam int NUM_WORDS = (NUM_BLOCKS + fcba_pkg::WORD_BITS - 1) / fcba_pkg::WORD_BITS;
    localparam int WIW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LAST_BITS = NUM_BLOCKS - fcba_pkg::WORD_BITS * (NUM_WORDS - 1);
    localparam logic [fcba_pkg::WORD_BITS-1:0] LAST_MASK =
        (LAST_BITS == fcba_pkg::WORD_BITS) ? '0 :
        ~((fcba_pkg::WORD_BITS'(1) << LAST_BITS) - fcba_pkg::WORD_BITS'(1));
    localparam logic [WIW-1:0] LAST_WORD = WIW'(NUM_WORDS - 1);
    localparam logic [BW-1:0]  LAST_BLK  = BW'(NUM_BLOCKS - 1);

    typedef enum logic [9:0] {
        S_CLR   = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_AWR   = 10'b0000001000,
        S_ALNK  = 10'b0000010000,
        S_FRD   = 10'b0000100000,
        S_FWR   = 10'b0001000000,
        S_NRD   = 10'b0010000000,
        S_NCHK  = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [BW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [WIW-1:0] scan_addr_reg, scan_addr_next;
    logic           scan_end_reg, scan_end_next;
    logic           chk_valid_reg, chk_valid_next;
    logic [WIW-1:0] chk_word_reg, chk_word_next;
    logic [WIW-1:0] found_word_reg, found_word_next;
    logic [4:0]     found_bit_reg, found_bit_next;
    logic [fcba_pkg::WORD_BITS-1:0] word_reg, word_next;
    logic [BW-1:0]  cur_reg, cur_next;
    logic [BW-1:0]  prev_reg, prev_next;
    logic           link_reg, link_next;
    logic [BW-1:0]  steps_reg, steps_next;
    fcba_pkg::rsp_t res_reg, res_next;
    fcba_pkg::rsp_t out_reg;
    logic           out_valid_reg, out_valid_next;
    logic           out_load;

    logic [fcba_pkg::WORD_BITS-1:0] used_mem [NUM_WORDS];
    logic [BW:0]                    link_mem [NUM_BLOCKS];
    logic [fcba_pkg::WORD_BITS-1:0] used_rdata_reg;
    logic [BW:0]                    link_rdata_reg;

    logic [WIW-1:0]                 used_raddr;
    logic                           used_we;
    logic [WIW-1:0]                 used_waddr;
    logic [fcba_pkg::WORD_BITS-1:0] used_wdata;
    logic                           link_we;
    logic [BW-1:0]                  link_waddr;
    logic [BW:0]                    link_wdata;

    logic [fcba_pkg::WORD_BITS-1:0] free_bits;
    logic                           found_any;
    logic [4:0]                     low_bit;
    logic [BW-1:0]                  new_blk;
    logic [BW-1:0]                  nxt_blk;
    logic                           in_range;
    logic                           walk_stop;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    assign in_range = (32'(in_data.block_index) < 32'(NUM_BLOCKS));
    assign new_blk  = BW'({found_word_reg, found_bit_reg});
    assign nxt_blk  = link_rdata_reg[BW-1:0];
    assign walk_stop = !link_rdata_reg[BW] || (32'(nxt_blk) >= 32'(NUM_BLOCKS))
                       || (steps_reg == LAST_BLK);

    always_comb
    begin
        free_bits = ~(used_rdata_reg | ((chk_word_reg == LAST_WORD) ? LAST_MASK : '0));
        found_any = |free_bits;
        low_bit   = '0;
        for (int k = fcba_pkg::WORD_BITS - 1; k >= 0; k--)
        begin
            if (free_bits[k])
            begin
                low_bit = 5'(k);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        scan_addr_next  = scan_addr_reg;
        scan_end_next   = scan_end_reg;
        chk_valid_next  = 1'b0;
        chk_word_next   = chk_word_reg;
        found_word_next = found_word_reg;
        found_bit_next  = found_bit_reg;
        word_next       = word_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        link_next       = link_reg;
        steps_next      = steps_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;

        used_raddr = (state_reg == S_SCAN) ? scan_addr_reg : WIW'(cur_reg >> fcba_pkg::WORD_SH);
        used_we    = 1'b0;
        used_waddr = WIW'(clr_cnt_reg >> fcba_pkg::WORD_SH);
        used_wdata = '0;
        link_we    = 1'b0;
        link_waddr = clr_cnt_reg;
        link_wdata = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                used_we = 1'b1;
                link_we = 1'b1;
                if (clr_cnt_reg == LAST_BLK)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + BW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next   = BW'(in_data.block_index);
                    prev_next  = BW'(in_data.block_index);
                    link_next  = in_data.link_previous;
                    steps_next = '0;
                    res_next   = '{result_block: '0, status: fcba_pkg::ST_RANGE};
                    case (in_data.command)
                        fcba_pkg::CMD_ALLOC:
                        begin
                            if (in_data.link_previous && !in_range)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                scan_addr_next = '0;
                                scan_end_next  = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        fcba_pkg::CMD_FREE:
                        begin
                            state_next = in_range ? S_FRD : S_FIN;
                        end
                        fcba_pkg::CMD_NEXT:
                        begin
                            state_next = in_range ? S_NRD : S_FIN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (chk_valid_reg && found_any)
                begin
                    found_word_next = chk_word_reg;
                    found_bit_next  = low_bit;
                    word_next       = used_rdata_reg;
                    state_next      = S_AWR;
                end
                else if (chk_valid_reg && (chk_word_reg == LAST_WORD))
                begin
                    res_next   = '{result_block: '0, status: fcba_pkg::ST_END};
                    state_next = S_FIN;
                end
                else
                begin
                    chk_valid_next = !scan_end_reg;
                    chk_word_next  = scan_addr_reg;
                    if (scan_addr_reg == LAST_WORD)
                    begin
                        scan_end_next = 1'b1;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + WIW'(1);
                    end
                end
            end
            S_AWR:
            begin
                used_we    = 1'b1;
                used_waddr = found_word_reg;
                used_wdata = word_reg | (fcba_pkg::WORD_BITS'(1) << found_bit_reg);
                link_we    = 1'b1;
                link_waddr = new_blk;
                link_wdata = '0;
                res_next   = '{result_block: 10'(new_blk), status: fcba_pkg::ST_OK};
                state_next = link_reg ? S_ALNK : S_FIN;
            end
            S_ALNK:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = {1'b1, new_blk};
                state_next = S_FIN;
            end
            S_FRD:
            begin
                state_next = S_FWR;
            end
            S_FWR:
            begin
                used_we    = 1'b1;
                used_waddr = WIW'(cur_reg >> fcba_pkg::WORD_SH);
                used_wdata = used_rdata_reg & ~(fcba_pkg::WORD_BITS'(1) << 5'(cur_reg));
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = '0;
                if (walk_stop)
                begin
                    res_next   = '{result_block: '0, status: fcba_pkg::ST_OK};
                    state_next = S_FIN;
                end
                else
                begin
                    cur_next   = nxt_blk;
                    steps_next = steps_reg + BW'(1);
                    state_next = S_FRD;
                end
            end
            S_NRD:
            begin
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                if (link_rdata_reg[BW])
                begin
                    res_next = '{result_block: 10'(nxt_blk), status: fcba_pkg::ST_OK};
                end
                else
                begin
                    res_next = '{result_block: '0, status: fcba_pkg::ST_END};
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            scan_end_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_end_reg  <= scan_end_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg  <= scan_addr_next;
        chk_word_reg   <= chk_word_next;
        found_word_reg <= found_word_next;
        found_bit_reg  <= found_bit_next;
        word_reg       <= word_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        link_reg       <= link_next;
        steps_reg      <= steps_next;
        res_reg        <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        used_rdata_reg <= used_mem[used_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[cur_reg];
    end

endmodule

FILE: bench/tb_fat_chain_block_allocator.sv
module tb_fat_chain_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS  = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int TOTAL_REQS  = 1100;
    localparam int WALK_MAX    = 12;

    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        fcba_pkg::req_t req;
        bit             drain;
    } pending_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    fcba_pkg::req_t in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    fcba_pkg::rsp_t out_data;

    // copy 0 plans the stimulus, copy 1 follows the block
    bit          used_mark[2][NUM_BLOCKS];
    int unsigned link_to[2][NUM_BLOCKS];
    bit          has_link[2][NUM_BLOCKS];

    pending_t       req_pending[$];
    fcba_pkg::rsp_t rsp_due[$];

    int n_total   = 0;
    int n_acc     = 0;
    int errors    = 0;
    int stall     = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit in_took   = 1'b0;

    fat_chain_block_allocator #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic fat_step(input int s, input fcba_pkg::req_t r, output fcba_pkg::rsp_t y);
        int unsigned idx;
        int unsigned cur;
        int unsigned nxt;
        int unsigned n;
        int unsigned steps;
        bit          more;
        bit          found;
        y = '0;
        y.status = fcba_pkg::ST_OK;
        idx = 32'(r.block_index);
        case (r.command)
            fcba_pkg::CMD_ALLOC:
            begin
                if (r.link_previous && idx >= NUM_BLOCKS)
                    y.status = fcba_pkg::ST_RANGE;
                else
                begin
                    found = 1'b0;
                    for (n = 0; n < NUM_BLOCKS && !found; n++)
                    begin
                        if (!used_mark[s][n])
                        begin
                            found = 1'b1;
                            used_mark[s][n] = 1'b1;
                            has_link[s][n] = 1'b0;
                            link_to[s][n] = 0;
                            if (r.link_previous)
                            begin
                                link_to[s][idx] = n;
                                has_link[s][idx] = 1'b1;
                            end
                            y.result_block = 10'(n);
                        end
                    end
                    if (!found)
                        y.status = fcba_pkg::ST_END;
                end
            end
            fcba_pkg::CMD_FREE:
            begin
                if (idx >= NUM_BLOCKS)
                    y.status = fcba_pkg::ST_RANGE;
                else
                begin
                    cur = idx;
                    for (steps = 0; steps < NUM_BLOCKS; steps++)
                    begin
                        nxt = link_to[s][cur];
                        more = has_link[s][cur];
                        used_mark[s][cur] = 1'b0;
                        has_link[s][cur] = 1'b0;
                        link_to[s][cur] = 0;
                        if (!more || nxt >= NUM_BLOCKS)
                            break;
                        cur = nxt;
                    end
                end
            end
            fcba_pkg::CMD_NEXT:
            begin
                if (idx >= NUM_BLOCKS)
                    y.status = fcba_pkg::ST_RANGE;
                else if (has_link[s][idx])
                    y.result_block = 10'(link_to[s][idx]);
                else
                    y.status = fcba_pkg::ST_END;
            end
            default:
                y.status = fcba_pkg::ST_RANGE;
        endcase
    endtask

    task automatic queue_req(input logic [1:0] cmd, input int unsigned idx, input bit link,
                             input bit drain, output fcba_pkg::rsp_t y);
        pending_t p;
        p.req.command       = cmd;
        p.req.block_index   = 10'(idx);
        p.req.link_previous = link;
        p.drain             = drain;
        fat_step(0, p.req, y);
        req_pending.push_back(p);
    endtask

    task automatic follow_chain(input int unsigned start, input bit drain);
        fcba_pkg::rsp_t y;
        queue_req(fcba_pkg::CMD_NEXT, start, 1'b0, drain, y);
        for (int i = 0; i < WALK_MAX && y.status == fcba_pkg::ST_OK; i++)
            queue_req(fcba_pkg::CMD_NEXT, 32'(y.result_block), 1'b0, 1'b0, y);
    endtask

    function automatic int unsigned lowest_free();
        for (int unsigned n = 0; n < NUM_BLOCKS; n++)
            if (!used_mark[0][n])
                return n;
        return 0;
    endfunction

    // mostly blocks at most two above the highest one in use
    function automatic int unsigned pick_block();
        int unsigned top;
        top = 0;
        for (int unsigned n = 0; n < NUM_BLOCKS; n++)
            if (used_mark[0][n])
                top = n;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, (top + 2 > NUM_BLOCKS - 1) ? NUM_BLOCKS - 1 : top + 2);
        return $urandom_range(0, NUM_BLOCKS - 1);
    endfunction

    function automatic int phase();
        if (n_acc * 3 < n_total)
            return 0;
        if (n_acc * 3 < n_total * 2)
            return 1;
        return 2;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    always @(negedge clk)
    begin
        logic           nv;
        fcba_pkg::req_t nd;
        int             idle_pct;
        idle_pct = (phase() == 0) ? 35 : (phase() == 1) ? 81 : 0;
        nv = in_valid && !in_took;
        nd = in_data;
        if (rst_n && !nv && req_pending.size() != 0
            && !(req_pending[0].drain && rsp_due.size() != 0)
            && $urandom_range(0, 99) >= idle_pct)
        begin
            nv = 1'b1;
            nd = req_pending[0].req;
            req_pending.delete(0);
        end
        in_valid <= nv;
        in_data  <= nd;
    end

    always @(negedge clk)
    begin
        int idle_pct;
        idle_pct = (phase() == 0) ? 81 : (phase() == 1) ? 35 : 0;
        if (!hold_done && n_total != 0 && n_acc * 6 >= n_total * 5)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        fcba_pkg::rsp_t y;
        if (!rst_n)
            in_took <= 1'b0;
        else
        begin
            in_took <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                fat_step(1, in_data, y);
                rsp_due.push_back(y);
                n_acc++;
            end
            if (out_valid && out_ready)
            begin
                if (rsp_due.size() == 0)
                    flag_error($sformatf("unexpected response block %0d status %0d",
                                         out_data.result_block, out_data.status));
                else
                begin
                    if (out_data.result_block != rsp_due[0].result_block)
                        flag_error($sformatf("result_block %0d, expected %0d",
                                             out_data.result_block, rsp_due[0].result_block));
                    if (out_data.status != rsp_due[0].status)
                        flag_error($sformatf("status %0d, expected %0d",
                                             out_data.status, rsp_due[0].status));
                    rsp_due.delete(0);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall <= 0;
        else if (stall >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall <= stall + 1;
    end

    initial
    begin
        fcba_pkg::rsp_t y;
        int unsigned    head;
        int unsigned    last;
        int unsigned    choice;
        int             first_rand;
        bit             drain;

        queue_req(fcba_pkg::CMD_ALLOC, 0, 1'b0, 1'b0, y);
        queue_req(fcba_pkg::CMD_ALLOC, 0, 1'b1, 1'b0, y);
        queue_req(fcba_pkg::CMD_NEXT, 0, 1'b0, 1'b0, y);
        queue_req(fcba_pkg::CMD_NEXT, 1, 1'b0, 1'b0, y);
        queue_req(fcba_pkg::CMD_NEXT, 1023, 1'b0, 1'b0, y);
        // link after a block that is still free
        queue_req(fcba_pkg::CMD_ALLOC, 1023, 1'b1, 1'b0, y);
        queue_req(fcba_pkg::CMD_NEXT, 1023, 1'b0, 1'b0, y);
        // previous block is the one being allocated: self loop
        last = lowest_free();
        queue_req(fcba_pkg::CMD_ALLOC, last, 1'b1, 1'b0, y);
        queue_req(fcba_pkg::CMD_NEXT, last, 1'b0, 1'b0, y);
        queue_req(fcba_pkg::CMD_FREE, last, 1'b0, 1'b0, y);
        queue_req(fcba_pkg::CMD_FREE, 1023, 1'b0, 1'b0, y);
        queue_req(fcba_pkg::CMD_FREE, 0, 1'b1, 1'b0, y);
        queue_req(fcba_pkg::CMD_NEXT, 0, 1'b0, 1'b0, y);
        queue_req(fcba_pkg::CMD_FREE, 682, 1'b0, 1'b0, y);
        queue_req(CMD_SPARE, 1023, 1'b1, 1'b0, y);
        queue_req(CMD_SPARE, 0, 1'b0, 1'b0, y);
        queue_req(fcba_pkg::CMD_ALLOC, 1023, 1'b0, 1'b0, y);
        queue_req(fcba_pkg::CMD_NEXT, 341, 1'b1, 1'b0, y);

        // one chain over every free block, then table full, then free it whole
        queue_req(fcba_pkg::CMD_ALLOC, $urandom_range(0, NUM_BLOCKS - 1), 1'b0, 1'b1, y);
        head = 32'(y.result_block);
        last = head;
        do
        begin
            queue_req(fcba_pkg::CMD_ALLOC, last, 1'b1, 1'b0, y);
            if (y.status == fcba_pkg::ST_OK)
                last = 32'(y.result_block);
        end
        while (y.status == fcba_pkg::ST_OK);
        queue_req(fcba_pkg::CMD_ALLOC, 0, 1'b0, 1'b0, y);
        queue_req(fcba_pkg::CMD_NEXT, last, 1'b0, 1'b0, y);
        follow_chain(head, 1'b0);
        queue_req(fcba_pkg::CMD_FREE, head, 1'b0, 1'b0, y);

        first_rand = req_pending.size();
        while (req_pending.size() < TOTAL_REQS)
        begin
            drain = (req_pending.size() == first_rand) || ($urandom_range(0, 49) == 0);
            choice = $urandom_range(0, 99);
            if (choice < 30)
            begin
                queue_req(fcba_pkg::CMD_ALLOC, $urandom_range(0, NUM_BLOCKS - 1), 1'b0, drain, y);
                head = 32'(y.result_block);
                last = head;
                repeat ($urandom_range(1, 8))
                begin
                    queue_req(fcba_pkg::CMD_ALLOC, last, 1'b1, 1'b0, y);
                    if (y.status == fcba_pkg::ST_OK)
                        last = 32'(y.result_block);
                end
                if ($urandom_range(0, 1))
                    follow_chain(head, 1'b0);
            end
            else if (choice < 48)
                follow_chain(pick_block(), drain);
            else if (choice < 68)
                queue_req(fcba_pkg::CMD_FREE, pick_block(), 1'($urandom_range(0, 1)), drain, y);
            else if (choice < 78)
                queue_req(fcba_pkg::CMD_ALLOC, pick_block(), 1'b1, drain, y);
            else if (choice < 83)
            begin
                last = lowest_free();
                queue_req(fcba_pkg::CMD_ALLOC, last, 1'b1, drain, y);
            end
            else
                queue_req(2'($urandom_range(0, 3)), $urandom_range(0, NUM_BLOCKS - 1),
                          1'($urandom_range(0, 1)), drain, y);
        end
        n_total = req_pending.size();

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        while (n_acc != n_total || rsp_due.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
